// ===== rtl/mdv_pkg.sv =====
// ----------------------------------------------------------------------------
// mdv_pkg
// Shared constants for the modulated delay vibrato block.
// ----------------------------------------------------------------------------
package mdv_pkg;

	localparam int LineDepth   = 160;
	localparam int SampleW     = 8;
	localparam int PhaseW      = 8;
	localparam int HalfW       = 7;
	localparam int CfgIndexW   = 1;
	localparam int CfgDataW    = 7;

	localparam logic [HalfW-1:0]   HalfPeriodRst = HalfW'(40);
	localparam logic [SampleW-1:0] SignFlip      = SampleW'(128);

	typedef enum logic [CfgIndexW-1:0] {
		CFG_MODE_SELECT = 1'b0,
		CFG_HALF_PERIOD = 1'b1
	} cfg_index_t;

	typedef enum logic {
		MODE_SAW    = 1'b0,
		MODE_SQUARE = 1'b1
	} mode_t;

endpackage

// ===== rtl/mdv_ram.sv =====
// ----------------------------------------------------------------------------
// mdv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mdv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mdv_addr_gen.sv =====
// ----------------------------------------------------------------------------
// mdv_addr_gen
// Write pointer, sawtooth delay and square phase counters; read address.
// ----------------------------------------------------------------------------
module mdv_addr_gen #(
	parameter int LINE_DEPTH = mdv_pkg::LineDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  mdv_pkg::mode_t                mode,
	input  logic [mdv_pkg::HalfW-1:0]     half_period,
	output logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
	output logic [$clog2(LINE_DEPTH)-1:0] rd_addr
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int PW = mdv_pkg::PhaseW + 2;

	logic [AW-1:0]               wp_q, wp_inc;
	logic [CW-1:0]               saw_q, saw_n;
	logic [mdv_pkg::PhaseW-1:0]  ph_q, ph_n;
	logic [SW-1:0]               saw_tmp, saw_diff;
	logic [PW-1:0]               ph_inc;

	always_comb begin
		wp_inc   = (wp_q == AW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		saw_tmp  = SW'(wp_q) + SW'(1);
		saw_diff = (saw_tmp >= SW'(saw_q)) ? saw_tmp - SW'(saw_q)
			: saw_tmp + SW'(LINE_DEPTH) - SW'(saw_q);
		saw_n    = (saw_q <= CW'(1)) ? CW'(LINE_DEPTH) : saw_q - 1'b1;
		ph_inc   = PW'(ph_q) + PW'(1);
		ph_n     = ph_q;
		rd_addr  = wp_q;
		case (mode)
			mdv_pkg::MODE_SAW: begin
				rd_addr = saw_diff[AW-1:0];
			end
			mdv_pkg::MODE_SQUARE: begin
				if (ph_q < {1'b0, half_period}) begin
					rd_addr = wp_q;
					ph_n    = ph_inc[mdv_pkg::PhaseW-1:0];
				end else begin
					rd_addr = wp_inc;
					if (ph_inc + PW'(1) >= {2'b00, half_period, 1'b0}) begin
						ph_n = '0;
					end else begin
						ph_n = ph_inc[mdv_pkg::PhaseW-1:0];
					end
				end
			end
			default: begin
				rd_addr = wp_q;
			end
		endcase
	end

	assign wr_addr = wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			saw_q <= CW'(LINE_DEPTH - 2);
			ph_q  <= '0;
		end else if (step) begin
			wp_q <= wp_inc;
			if (mode == mdv_pkg::MODE_SAW) begin
				saw_q <= saw_n;
			end else begin
				ph_q <= ph_n;
			end
		end
	end

endmodule

// ===== rtl/modulated_delay_vibrato.sv =====
// ----------------------------------------------------------------------------
// modulated_delay_vibrato
// Vibrato by a modulated circular delay line, sawtooth or square modulation.
// Each beat goes from input to output through the RAM read, then the output register.
// Throughput: one beat per cycle while m_tready does not stall the output, set by
// the single write and read port of the delay line RAM, which are used once per beat.
// Reset: counters, config and valid bits clear at once; unwritten entries
// read as zero, so the line behaves as cleared without a sweep.
// ----------------------------------------------------------------------------
module modulated_delay_vibrato #(
	parameter int LINE_DEPTH = mdv_pkg::LineDepth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mdv_pkg::SampleW-1:0]     s_tdata,   // [7:0] sample_in
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mdv_pkg::SampleW-1:0]     m_tdata,   // [7:0] sample_out
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mdv_pkg::CfgIndexW-1:0]   cfg_index,
	input  logic [mdv_pkg::CfgDataW-1:0]    cfg_data
);

	localparam int AW = $clog2(LINE_DEPTH);

	mdv_pkg::mode_t               mode_q;
	logic [mdv_pkg::HalfW-1:0]    half_q;
	logic [LINE_DEPTH-1:0]        vld_q;
	logic [AW-1:0]                wr_addr, rd_addr;
	logic                         s_acc, s1_move;
	logic                         valid_s1, fwd_s1, hit_s1;
	logic [mdv_pkg::SampleW-1:0]  sample_s1, rdata, sel_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mdv_pkg::MODE_SAW;
			half_q <= mdv_pkg::HalfPeriodRst;
		end else if (cfg_valid) begin
			case (mdv_pkg::cfg_index_t'(cfg_index))
				mdv_pkg::CFG_MODE_SELECT: mode_q <= mdv_pkg::mode_t'(cfg_data[0]);
				mdv_pkg::CFG_HALF_PERIOD: half_q <= cfg_data[mdv_pkg::HalfW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s1_move  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || s1_move;
	assign s_acc    = s_tvalid && s_tready;

	mdv_addr_gen #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_addr_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s_acc),
		.mode        (mode_q),
		.half_period (half_q),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr)
	);

	mdv_ram #(
		.WIDTH(mdv_pkg::SampleW),
		.DEPTH(LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (s_acc),
		.waddr (wr_addr),
		.wdata (s_tdata),
		.re    (s_acc),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (s_acc) begin
				vld_q[wr_addr] <= 1'b1;
				valid_s1       <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			sample_s1 <= s_tdata;
			fwd_s1    <= (rd_addr == wr_addr);
			hit_s1    <= vld_q[rd_addr];
		end
	end

	always_comb begin
		if (fwd_s1) begin
			sel_data = sample_s1;
		end else if (hit_s1) begin
			sel_data = rdata;
		end else begin
			sel_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_move) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_tdata <= sel_data ^ mdv_pkg::SignFlip;
		end
	end

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> (rd_addr < AW'(LINE_DEPTH)) && (wr_addr < AW'(LINE_DEPTH)))
		else $error("delay line address out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled with free pipeline slot");

	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> valid_s1)
		else $error("accepted beat missing from read stage");

	a_move_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> m_tvalid)
		else $error("read stage beat missing from output");

endmodule
